// ----- rtl/core/sfadd_pkg.sv -----
// -----------------------------------------------------------------------------
// sfadd_pkg
// shared types and constants of the truncating single-precision adder
// -----------------------------------------------------------------------------
package sfadd_pkg;

  localparam logic [22:0] FracMask  = 23'h7FFFFF;
  localparam logic [7:0]  ExpMask   = 8'hFF;
  localparam logic [7:0]  ExpBias   = 8'd127;
  localparam logic [7:0]  MaxShift  = 8'd25;

  // input word
  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } sfadd_in_t;

  // stage 1 -> stage 2: aligned mantissas
  typedef struct packed {
    logic        sign_b;
    logic        sign_s;
    logic [23:0] mant_b;
    logic [23:0] mant_s;
    logic [7:0]  expo;
  } sfadd_align_t;

  // stage 2 -> stage 3: signed sum as magnitude
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [24:0] mag;
    logic [7:0]  expo;
  } sfadd_sum_t;

  // leading zero count of a 24-bit value, bit 23 first
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/sfadd_if.sv -----
// -----------------------------------------------------------------------------
// sfadd_if
// valid/ready channel carrying one word of a given payload width
// -----------------------------------------------------------------------------
interface sfadd_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/single_float_adder_truncating.sv -----
// -----------------------------------------------------------------------------
// single_float_adder_truncating
// three-stage truncating single-precision adder
// -----------------------------------------------------------------------------
// pipeline: 3 register stages (s1_q, s2_q, s3_q) between the accepting edge and the result word
// throughput: one word per cycle; a stalled output holds the whole pipe
// reset: asynchronous active low, clears all stage valid bits
module single_float_adder_truncating import sfadd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  sfadd_if.sink    in_i,
  sfadd_if.source  out_o
);
  sfadd_in_t    s0_d;
  sfadd_align_t s1_d, s1_q;
  sfadd_sum_t   s2_d;
  logic [31:0]  s3_d, s3_q;
  logic         v0_q, v1_q, v2_q;
  sfadd_sum_t   s2_q;
  logic         adv;

  // whole pipe moves unless the output word is waiting
  assign adv       = !v2_q || out_o.ready;
  assign in_i.ready = adv;
  assign s0_d      = in_i.data;

  // stage 1: exponent compare and alignment shift on the incoming word
  sfadd_align u_align (.in_i(s0_d), .out_o(s1_d));
  // stage 2: signed add
  sfadd_addsub u_add (.in_i(s1_q), .out_o(s2_d));
  // stage 3: normalize and pack
  sfadd_norm u_norm (.in_i(s2_q), .sum_o(s3_d));

  // v0_q marks s1_q, v1_q marks s2_q, v2_q marks s3_q
  assign out_o.valid = v2_q;
  assign out_o.data  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end
endmodule

// ----- rtl/core/sfadd_align.sv -----
// -----------------------------------------------------------------------------
// sfadd_align
// orders operands by exponent and shifts the smaller mantissa right
// -----------------------------------------------------------------------------
module sfadd_align import sfadd_pkg::*; (
  input  sfadd_in_t    in_i,
  output sfadd_align_t out_o
);
  logic [7:0]  ex, ey, shift;
  logic [31:0] big, sml;
  logic [23:0] ms;

  always_comb begin
    ex    = in_i.operand_a[30:23] & ExpMask;
    ey    = in_i.operand_b[30:23] & ExpMask;
    big   = (ex < ey) ? in_i.operand_b : in_i.operand_a;
    sml   = (ex < ey) ? in_i.operand_a : in_i.operand_b;
    shift = big[30:23] - sml[30:23];
    ms    = {1'b1, sml[22:0] & FracMask};
    out_o.sign_b = big[31];
    out_o.sign_s = sml[31];
    out_o.mant_b = {1'b1, big[22:0]};
    out_o.mant_s = (shift >= MaxShift) ? 24'd0 : (ms >> shift[4:0]);
    out_o.expo   = big[30:23];
  end
endmodule

// ----- rtl/core/sfadd_addsub.sv -----
// -----------------------------------------------------------------------------
// sfadd_addsub
// signed mantissa add, result as sign and magnitude
// -----------------------------------------------------------------------------
module sfadd_addsub import sfadd_pkg::*; (
  input  sfadd_align_t in_i,
  output sfadd_sum_t   out_o
);
  logic signed [25:0] sb, ss, total;

  always_comb begin
    sb    = in_i.sign_b ? -$signed({2'b00, in_i.mant_b}) : $signed({2'b00, in_i.mant_b});
    ss    = in_i.sign_s ? -$signed({2'b00, in_i.mant_s}) : $signed({2'b00, in_i.mant_s});
    total = sb + ss;
    out_o.zero = (total == 26'sd0);
    out_o.neg  = total[25];
    out_o.mag  = total[25] ? 25'(-total) : total[24:0];
    out_o.expo = in_i.expo;
  end
endmodule

// ----- rtl/core/sfadd_norm.sv -----
// -----------------------------------------------------------------------------
// sfadd_norm
// normalizes the magnitude and packs the result word
// -----------------------------------------------------------------------------
module sfadd_norm import sfadd_pkg::*; (
  input  sfadd_sum_t  in_i,
  output logic [31:0] sum_o
);
  logic [4:0]  lz;
  logic [23:0] m;
  logic [7:0]  e;

  always_comb begin
    lz = lzc24(in_i.mag[23:0]);
    if (in_i.mag[24]) begin
      m = in_i.mag[24:1];
      e = in_i.expo + 8'd1;
    end else begin
      m = in_i.mag[23:0] << lz;
      e = in_i.expo - {3'd0, lz};
    end
    sum_o = in_i.zero ? 32'd0 : {in_i.neg, e & ExpMask, m[22:0] & FracMask};
  end
endmodule
